// File: sv/drst_pkg.sv
// Shared types and codes for the dirty row span tracker.
// No dependencies; drst_front, drst_back and the top level import this package.
package drst_pkg;

   // Action codes on the request port
   localparam logic [1:0] ACT_INVALIDATE = 2'd0;
   localparam logic [1:0] ACT_VALIDATE   = 2'd1;
   localparam logic [1:0] ACT_READ       = 2'd2;

   // Span bounds hold values up to 511 inclusive; row bounds up to 255 inclusive
   localparam int SPAN_W = 9;
   localparam int ROW_W  = 8;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_NOP   = 2'd0;
   localparam kind_type KIND_WIDEN = 2'd1;
   localparam kind_type KIND_TRIM  = 2'd2;
   localparam kind_type KIND_READ  = 2'd3;

   typedef struct packed {
      kind_type              kind;
      logic [SPAN_W-1:0]     col_lo;
      logic [SPAN_W-1:0]     col_hi;
      logic [ROW_W-1:0]      row_lo;
      logic [ROW_W-1:0]      row_hi;
   } item_type;

endpackage

// File: sv/drst_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module drst_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/drst_front.sv
// Request front end: clamps the rectangle, classifies the request and queues it.
// Depends on drst_pkg.
module drst_front #(
   parameter int COLUMNS = 128,
   parameter int ROWS    = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_action,
   input  logic [6:0]        req_col_x,
   input  logic [5:0]        req_row_y,
   input  logic [7:0]        req_width_cols,
   input  logic [6:0]        req_height_rows,
   output logic              q_valid,
   output drst_pkg::item_type q_item,
   input  logic              q_pop
);
   import drst_pkg::*;

   localparam logic [9:0]       COL_LIM = 10'(COLUMNS);
   localparam logic [ROW_W-1:0] ROW_LIM = ROW_W'(ROWS);

   logic [9:0]       col_end;
   logic [9:0]       col_clamp;
   logic [ROW_W-1:0] row_end;
   logic [ROW_W-1:0] row_clamp;
   logic             rect_empty;
   item_type         item;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   always_comb begin
      col_end   = {3'b0, req_col_x} + {2'b0, req_width_cols};
      col_clamp = (col_end > COL_LIM) ? COL_LIM : col_end;
      row_end   = {2'b0, req_row_y} + {1'b0, req_height_rows};
      row_clamp = (row_end > ROW_LIM) ? ROW_LIM : row_end;
      rect_empty = (col_clamp <= {3'b0, req_col_x}) || (row_clamp <= {2'b0, req_row_y});

      item.col_lo = {2'b0, req_col_x};
      item.col_hi = col_clamp[SPAN_W-1:0];
      item.row_lo = {2'b0, req_row_y};
      item.row_hi = row_clamp;
      case (req_action)
         ACT_INVALIDATE: item.kind = rect_empty ? KIND_NOP : KIND_WIDEN;
         ACT_VALIDATE:   item.kind = rect_empty ? KIND_NOP : KIND_TRIM;
         ACT_READ:       item.kind = ({2'b0, req_row_y} < ROW_LIM) ? KIND_READ : KIND_NOP;
         default:        item.kind = KIND_NOP;
      endcase
   end

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// File: sv/drst_back.sv
// Back end: walks the rows of a rectangle with a read-modify-write per row,
// answers row reads and drives the result strobe. Depends on drst_pkg, drst_ram.
module drst_back #(
   parameter int ROWS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  drst_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   output logic [7:0]         rsp_span_start,
   output logic [7:0]         rsp_span_end,
   output logic               rsp_row_dirty
);
   import drst_pkg::*;

   localparam int AW = $clog2(ROWS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_RDWAIT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [ROWS-1:0]   flag_ff, flag_in;
   logic              p_valid_ff, p_valid_in;
   logic [AW-1:0]     p_row_ff, p_row_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ROW_W-1:0]  end_ff, end_in;
   kind_type          kind_ff, kind_in;
   logic [SPAN_W-1:0] col_lo_ff, col_lo_in;
   logic [SPAN_W-1:0] col_hi_ff, col_hi_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_start_ff, rsp_start_in;
   logic [7:0]        rsp_end_ff, rsp_end_in;
   logic              rsp_dirty_ff, rsp_dirty_in;

   logic [AW-1:0]       rd_addr;
   logic [2*SPAN_W-1:0] rd_data;
   logic [SPAN_W-1:0]   cur_s, cur_e, new_s, new_e;
   logic                cur_dirty, new_dirty;

   drst_ram #(
      .WIDTH(2 * SPAN_W),
      .DEPTH(ROWS)
   ) u_span_ram (
      .clock   (clock),
      .wr_en   (p_valid_ff),
      .wr_addr (p_row_ff),
      .wr_data ({new_s, new_e}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Row update for the row whose stored span just came back
   always_comb begin
      cur_s     = rd_data[2*SPAN_W-1:SPAN_W];
      cur_e     = rd_data[SPAN_W-1:0];
      cur_dirty = flag_ff[p_row_ff];
      new_s     = cur_s;
      new_e     = cur_e;
      new_dirty = cur_dirty;
      if (kind_ff == KIND_WIDEN) begin
         if (!cur_dirty) begin
            new_dirty = 1'b1;
            new_s     = col_lo_ff;
            new_e     = col_hi_ff;
         end else begin
            if (cur_s > col_lo_ff) new_s = col_lo_ff;
            if (cur_e < col_hi_ff) new_e = col_hi_ff;
         end
      end else if (cur_dirty) begin
         if (cur_s >= col_lo_ff && cur_e <= col_hi_ff) begin
            new_dirty = 1'b0;
         end else if (cur_s >= col_lo_ff && col_hi_ff > cur_s) begin
            new_s = col_hi_ff;
         end else if (cur_e <= col_hi_ff && col_lo_ff < cur_e) begin
            new_e = col_lo_ff;
         end
      end
   end

   assign rd_addr = (state_ff == ST_IDLE) ? q_item.row_lo[AW-1:0] : row_ff[AW-1:0];
   assign q_pop   = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      state_in     = state_ff;
      flag_in      = flag_ff;
      p_valid_in   = 1'b0;
      p_row_in     = p_row_ff;
      row_in       = row_ff;
      end_in       = end_ff;
      kind_in      = kind_ff;
      col_lo_in    = col_lo_ff;
      col_hi_in    = col_hi_ff;
      rsp_valid_in = 1'b0;
      rsp_start_in = 8'd0;
      rsp_end_in   = 8'd0;
      rsp_dirty_in = 1'b0;

      if (p_valid_ff) begin
         flag_in[p_row_ff] = new_dirty;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_item.kind) inside
                  KIND_WIDEN, KIND_TRIM: begin
                     kind_in   = q_item.kind;
                     col_lo_in = q_item.col_lo;
                     col_hi_in = q_item.col_hi;
                     row_in    = q_item.row_lo;
                     end_in    = q_item.row_hi;
                     state_in  = ST_WALK;
                  end
                  KIND_READ: begin
                     p_row_in = q_item.row_lo[AW-1:0];
                     state_in = ST_RDWAIT;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (row_ff < end_ff) begin
               // issue the read for this row; the write lands next cycle
               p_valid_in = 1'b1;
               p_row_in   = row_ff[AW-1:0];
               row_in     = row_ff + 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_RDWAIT: begin
            rsp_valid_in = 1'b1;
            if (flag_ff[p_row_ff]) begin
               rsp_dirty_in = 1'b1;
               rsp_start_in = cur_s[7:0];
               rsp_end_in   = cur_e[7:0];
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flag_ff      <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_row_ff     <= p_row_in;
      row_ff       <= row_in;
      end_ff       <= end_in;
      kind_ff      <= kind_in;
      col_lo_ff    <= col_lo_in;
      col_hi_ff    <= col_hi_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_dirty_ff <= rsp_dirty_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_span_start = rsp_start_ff;
   assign rsp_span_end   = rsp_end_ff;
   assign rsp_row_dirty  = rsp_dirty_ff;

endmodule

// File: sv/dirty_row_span_tracker.sv
// Dirty row span tracker. A request is accepted on start while busy is low and
// queued (two entries) for the row engine, which finishes one request before it
// pops the next. One result strobe per request; a rectangle takes one span RAM
// read-modify-write per row. Reset clears all dirty flags at once; results are
// never held off by the receiver.
module dirty_row_span_tracker #(
   parameter int COLUMNS = 128,
   parameter int ROWS    = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_action,
   input  logic [6:0] req_col_x,
   input  logic [5:0] req_row_y,
   input  logic [7:0] req_width_cols,
   input  logic [6:0] req_height_rows,
   output logic       rsp_valid,
   output logic [7:0] rsp_span_start,
   output logic [7:0] rsp_span_end,
   output logic       rsp_row_dirty
);
   import drst_pkg::*;

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   drst_front #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_col_x      (req_col_x),
      .req_row_y      (req_row_y),
      .req_width_cols (req_width_cols),
      .req_height_rows(req_height_rows),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   drst_back #(
      .ROWS(ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_span_start (rsp_span_start),
      .rsp_span_end   (rsp_span_end),
      .rsp_row_dirty  (rsp_row_dirty)
   );

endmodule
